[rtl/smv_pkg.sv]
package smv_pkg;

   localparam int MaxDim     = 64;
   localparam int IdxWidth   = 6;
   localparam int DimWidth   = 7;
   localparam int ValWidth   = 32;

   localparam logic [1:0] ModeLoad   = 2'd0;
   localparam logic [1:0] ModeEntry  = 2'd1;
   localparam logic [1:0] ModeFinish = 2'd2;

   localparam logic [1:0] StoreGeneral = 2'd0;
   localparam logic [1:0] StoreUpper   = 2'd1;
   localparam logic [1:0] StoreLower   = 2'd2;

   localparam logic [2:0] RegIndexBase = 3'd0;
   localparam logic [2:0] RegStorage   = 3'd1;
   localparam logic [2:0] RegUnitDiag  = 3'd2;
   localparam logic [2:0] RegRowCount  = 3'd3;
   localparam logic [2:0] RegColCount  = 3'd4;

   // Classified command from the front end to the back end.
   typedef enum logic [1:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_ENTRY,
      CMD_FINISH
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type          kind;
      logic                  err;     // sets sticky error
      logic                  mirror;  // second update y[col] += a*x[row]
      logic                  skip;    // entry ignored
      logic                  diag;    // add unit diagonal on finish
      logic [IdxWidth-1:0]   row;
      logic [IdxWidth-1:0]   col;
      logic [DimWidth-1:0]   rows;
      logic [ValWidth-1:0]   value;
   } cmd_type;

   localparam int CmdWidth = $bits(cmd_type);

   function automatic logic [DimWidth-1:0] clamp_dim(input logic [DimWidth-1:0] v);
      logic [DimWidth-1:0] r;
      r = v;
      if (v == '0) r = DimWidth'(1);
      else if (v > DimWidth'(MaxDim)) r = DimWidth'(MaxDim);
      return r;
   endfunction

endpackage

[rtl/smv_ram.sv]
module smv_ram #(
   parameter int Width = 32,
   parameter int Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

[rtl/smv_front.sv]
module smv_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [1:0]           mode,
   input  logic [6:0]           row_index,
   input  logic [6:0]           col_index,
   input  logic [31:0]          value,
   input  logic                 index_base,
   input  logic [1:0]           storage_mode,
   input  logic                 unit_diagonal,
   input  logic [6:0]           row_count,
   input  logic [6:0]           col_count,
   output logic                 cmd_valid,
   input  logic                 cmd_ready,
   output smv_pkg::cmd_type     cmd
);
   // two-entry queue
   smv_pkg::cmd_type q_ff [2];
   logic [1:0] wp_ff, rp_ff;
   logic [1:0] wp_in, rp_in;
   smv_pkg::cmd_type c;
   logic [6:0] rows, cols, r7, c7;
   logic r_ok, c_ok, sym, push, pop;

   always_comb begin
      rows = smv_pkg::clamp_dim(row_count);
      cols = smv_pkg::clamp_dim(col_count);
      r7 = row_index - 7'(index_base);
      c7 = col_index - 7'(index_base);
      c = '0;
      c.rows = rows;
      c.value = value;
      c.row = r7[5:0];
      c.col = c7[5:0];
      sym = (storage_mode == smv_pkg::StoreUpper || storage_mode == smv_pkg::StoreLower)
            && rows == cols;
      case (mode)
         smv_pkg::ModeLoad: begin
            r_ok = row_index >= 7'(index_base) && r7 < cols;
            c_ok = 1'b1;
            c.kind = smv_pkg::CMD_LOAD;
            c.err = !r_ok;
         end
         smv_pkg::ModeEntry: begin
            r_ok = row_index >= 7'(index_base) && r7 < rows;
            c_ok = col_index >= 7'(index_base) && c7 < cols;
            c.kind = smv_pkg::CMD_ENTRY;
            c.err = !(r_ok && c_ok);
            if (sym && r7 != c7) begin
               if ((storage_mode == smv_pkg::StoreUpper) ? (r7 < c7) : (r7 > c7))
                  c.mirror = 1'b1;
               else
                  c.skip = 1'b1;
            end
         end
         smv_pkg::ModeFinish: begin
            r_ok = 1'b1;
            c_ok = 1'b1;
            c.kind = smv_pkg::CMD_FINISH;
            c.diag = unit_diagonal && rows == cols;
            c.err = unit_diagonal && rows != cols;
         end
         default: begin
            r_ok = 1'b1;
            c_ok = 1'b1;
            c.kind = smv_pkg::CMD_NONE;
         end
      endcase
   end

   assign in_ready  = (wp_ff - rp_ff) != 2'd2;
   assign cmd_valid = wp_ff != rp_ff;
   assign cmd       = q_ff[rp_ff[0]];
   assign push      = in_valid && in_ready && c.kind != smv_pkg::CMD_NONE;
   assign pop       = cmd_valid && cmd_ready;
   assign wp_in     = wp_ff + 2'(push);
   assign rp_in     = rp_ff + 2'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
      end
      if (push) q_ff[wp_ff[0]] <= c;
   end
endmodule

[rtl/smv_back.sv]
module smv_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 cmd_valid,
   output logic                 cmd_ready,
   input  smv_pkg::cmd_type     cmd,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [5:0]           out_index,
   output logic [31:0]          out_value,
   output logic                 out_last,
   output logic                 out_error
);
   typedef enum logic [3:0] {
      S_IDLE, S_RD1, S_WR1, S_RD2, S_WR2, S_CLR,
      S_FRD, S_FWAIT, S_FOUT
   } state_type;

   state_type state_ff;
   smv_pkg::cmd_type c_ff;
   logic err_ff;
   logic [63:0] yv_ff;          // y entry valid (else zero)
   logic [6:0] cnt_ff;
   logic out_valid_ff, out_last_ff, out_error_ff;
   logic [5:0] out_index_ff;
   logic [31:0] out_value_ff;
   logic [31:0] prod_ff;

   logic x_we, y_we;
   logic [5:0] x_wa, x_ra, y_wa, y_ra;
   logic [31:0] x_wd, x_rd, y_wd, y_rd, y_cur;

   smv_ram #(.Width(32), .Depth(smv_pkg::MaxDim)) u_x (
      .clock, .wr_en(x_we), .wr_addr(x_wa), .wr_data(x_wd),
      .rd_addr(x_ra), .rd_data(x_rd));
   smv_ram #(.Width(32), .Depth(smv_pkg::MaxDim)) u_y (
      .clock, .wr_en(y_we), .wr_addr(y_wa), .wr_data(y_wd),
      .rd_addr(y_ra), .rd_data(y_rd));

   assign cmd_ready = state_ff == S_IDLE;
   assign out_valid = out_valid_ff;
   assign out_index = out_index_ff;
   assign out_value = out_value_ff;
   assign out_last  = out_last_ff;
   assign out_error = out_error_ff;

   logic [5:0] wa;
   always_comb begin
      wa = (state_ff == S_WR2) ? c_ff.col : c_ff.row;
      case (state_ff)
         S_IDLE: begin
            x_ra = cmd.col;
            y_ra = cmd.row;
         end
         S_RD1: begin
            x_ra = c_ff.col;
            y_ra = c_ff.row;
         end
         S_WR1: begin
            x_ra = c_ff.row;
            y_ra = c_ff.col;
         end
         S_RD2: begin
            x_ra = c_ff.row;
            y_ra = c_ff.col;
         end
         default: begin
            x_ra = cnt_ff[5:0];
            y_ra = cnt_ff[5:0];
         end
      endcase
      x_we = state_ff == S_IDLE && cmd_valid && cmd.kind == smv_pkg::CMD_LOAD && !cmd.err;
      x_wa = cmd.row;
      x_wd = cmd.value;
      y_cur = yv_ff[(state_ff == S_FOUT) ? cnt_ff[5:0] : wa] ? y_rd : '0;
      y_we = state_ff == S_WR1 || state_ff == S_WR2;
      y_wa = wa;
      y_wd = y_cur + prod_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         err_ff <= 1'b0;
         yv_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: if (cmd_valid) begin
               c_ff <= cmd;
               if (cmd.err) err_ff <= 1'b1;
               cnt_ff <= '0;
               if (cmd.kind == smv_pkg::CMD_ENTRY && !cmd.err && !cmd.skip)
                  state_ff <= S_RD1;
               else if (cmd.kind == smv_pkg::CMD_FINISH)
                  state_ff <= S_FRD;
            end
            S_RD1: begin
               prod_ff <= c_ff.value * x_rd;
               state_ff <= S_WR1;
            end
            S_WR1: begin
               yv_ff[c_ff.row] <= 1'b1;
               state_ff <= c_ff.mirror ? S_RD2 : S_IDLE;
            end
            S_RD2: begin
               prod_ff <= c_ff.value * x_rd;
               state_ff <= S_WR2;
            end
            S_WR2: begin
               yv_ff[c_ff.col] <= 1'b1;
               state_ff <= S_IDLE;
            end
            S_FRD: state_ff <= S_FWAIT;   // read of y and x in flight
            S_FWAIT: begin
               prod_ff <= c_ff.diag ? x_rd : '0;
               state_ff <= S_FOUT;
            end
            S_FOUT: if (!out_valid_ff || out_ready) begin
               out_valid_ff <= 1'b1;
               out_index_ff <= cnt_ff[5:0];
               out_value_ff <= y_cur + prod_ff;
               out_last_ff  <= cnt_ff + 7'd1 == c_ff.rows;
               out_error_ff <= err_ff;
               if (cnt_ff + 7'd1 == c_ff.rows) state_ff <= S_CLR;
               else state_ff <= S_FRD;
               cnt_ff <= cnt_ff + 7'd1;
            end
            S_CLR: begin
               yv_ff <= '0;
               err_ff <= 1'b0;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
         if (out_valid_ff && out_ready && !(state_ff == S_FOUT))
            out_valid_ff <= 1'b0;
      end
   end
endmodule

[rtl/sparse_matvec_csr_symmetric.sv]
// Load item: written to x when taken from the queue. General nonzero: RD1, WR1;
// symmetric mirrored nonzero adds RD2, WR2 (one read, one read-modify-write of y).
// Finish: FRD, FWAIT (registered y/x reads), FOUT per row emitted, then CLR.
// A 2-word queue decouples input acceptance from execution.
// Synchronous active-high reset: y reads as zero, error clear, registers to
// 0,0,0,64,64; x memory is undefined until written.
module sparse_matvec_csr_symmetric (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [1:0] mode, [8:2] row_index, [15:9] col_index, [47:16] value
   input  logic [47:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [5:0] result_index, [37:6] result_value, zero fill
   output logic [39:0] rsp_tdata,
   output logic        rsp_tlast,
   // [0] error
   output logic        rsp_tuser,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [6:0]  csr_data
);
   logic       index_base_ff;
   logic [1:0] storage_mode_ff;
   logic       unit_diagonal_ff;
   logic [6:0] row_count_ff, col_count_ff;

   logic cmd_valid, cmd_ready;
   smv_pkg::cmd_type cmd;
   logic [5:0] o_idx;
   logic [31:0] o_val;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         index_base_ff    <= 1'b0;
         storage_mode_ff  <= smv_pkg::StoreGeneral;
         unit_diagonal_ff <= 1'b0;
         row_count_ff     <= 7'd64;
         col_count_ff     <= 7'd64;
      end else if (csr_valid) begin
         case (csr_index)
            smv_pkg::RegIndexBase: index_base_ff    <= csr_data[0];
            smv_pkg::RegStorage:   storage_mode_ff  <= csr_data[1:0];
            smv_pkg::RegUnitDiag:  unit_diagonal_ff <= csr_data[0];
            smv_pkg::RegRowCount:  row_count_ff     <= csr_data;
            smv_pkg::RegColCount:  col_count_ff     <= csr_data;
            default: ;
         endcase
      end
   end

   smv_front u_front (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready),
      .mode(req_tdata[1:0]), .row_index(req_tdata[8:2]),
      .col_index(req_tdata[15:9]), .value(req_tdata[47:16]),
      .index_base(index_base_ff), .storage_mode(storage_mode_ff),
      .unit_diagonal(unit_diagonal_ff), .row_count(row_count_ff),
      .col_count(col_count_ff),
      .cmd_valid, .cmd_ready, .cmd);

   smv_back u_back (
      .clock, .reset, .cmd_valid, .cmd_ready, .cmd,
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_index(o_idx), .out_value(o_val),
      .out_last(rsp_tlast), .out_error(rsp_tuser));

   assign rsp_tdata = {2'b00, o_val, o_idx};
endmodule
